FILE: rtl/keyed_slot_allocate_and_count_unit_assert.svh
// Assertion macros for the checker file ksac_checker.sv.
`ifndef KEYED_SLOT_ALLOCATE_AND_COUNT_UNIT_ASSERT_SVH
`define KEYED_SLOT_ALLOCATE_AND_COUNT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KSAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/ksac_pkg.sv
`timescale 1ns / 1ps

package ksac_pkg;

  localparam int SLOTS        = 16;
  localparam int CNT_DEPTH    = SLOTS + 1;
  localparam int IDX_W        = $clog2(CNT_DEPTH);
  localparam int ID_W         = 32;
  localparam int PRI_W        = 8;
  localparam int CNT_W        = 64;
  localparam int SLOT_INDEX_W = 5;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic en;
    idx_t addr;
    cnt_t data;
  } ram_wr_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

endpackage

FILE: rtl/keyed_slot_allocate_and_count_unit.sv
`timescale 1ns / 1ps

// Per-key enqueue counter table. Each input word (work id, priority) is compared
// in parallel against all occupied slots on acceptance; the first empty or
// matching slot is taken, or the overflow slot (index SLOTS) when all slots hold
// other keys. The slot's 64-bit counter is then incremented by a read-modify-write
// of a counter RAM with separate read and write ports and a registered read,
// so one word passes through the accept phase (compare and RAM read) and the
// update phase (add, write back, load the result register). A result held by a
// stalled consumer stalls the update phase. Counters read as zero until first
// written, so no clearing pass is needed and the block is ready straight out of
// reset.
module keyed_slot_allocate_and_count_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ksac_pkg::ID_W-1:0]           in_work_id,
  input  logic [ksac_pkg::PRI_W-1:0]          in_priority_req,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ksac_pkg::SLOT_INDEX_W-1:0]   out_slot_index,
  output logic                                out_newly_allocated,
  output logic [ksac_pkg::CNT_W-1:0]          out_enqueue_count
);

  ksac_pkg::state_t state_r, state_nxt;

  logic [ksac_pkg::SLOTS-1:0]     used_r;
  logic [ksac_pkg::ID_W-1:0]      key_id_r  [ksac_pkg::SLOTS];
  logic [ksac_pkg::PRI_W-1:0]     key_pri_r [ksac_pkg::SLOTS];
  logic [ksac_pkg::CNT_DEPTH-1:0] cnt_vld_r;

  ksac_pkg::idx_t             idx_r;
  logic                       fresh_r;
  logic [ksac_pkg::ID_W-1:0]  id_r;
  logic [ksac_pkg::PRI_W-1:0] pri_r;
  logic                       rd_vld_r;

  logic                       out_valid_r;
  ksac_pkg::idx_t             out_idx_r;
  logic                       out_fresh_r;
  ksac_pkg::cnt_t             out_cnt_r;

  ksac_pkg::idx_t             pick_idx;
  logic                       pick_fresh;
  logic                       accept;
  logic                       finish;
  ksac_pkg::cnt_t             rd_data;
  ksac_pkg::cnt_t             cnt_sum;
  ksac_pkg::ram_wr_t          wr;

  // first empty or matching slot; scanned from the top so the lowest wins
  always_comb begin
    pick_idx   = ksac_pkg::idx_t'(ksac_pkg::SLOTS);
    pick_fresh = 1'b0;
    for (int i = ksac_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i] || (key_id_r[i] == in_work_id && key_pri_r[i] == in_priority_req)) begin
        pick_idx   = ksac_pkg::idx_t'(i);
        pick_fresh = !used_r[i];
      end
    end
  end

  assign accept  = in_valid && in_ready;
  assign finish  = (state_r == ksac_pkg::ST_BUSY) && (!out_valid_r || out_ready);
  assign cnt_sum = (rd_vld_r ? rd_data : '0) + ksac_pkg::cnt_t'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ksac_pkg::ST_IDLE: if (accept) state_nxt = ksac_pkg::ST_BUSY;
      ksac_pkg::ST_BUSY: if (finish) state_nxt = ksac_pkg::ST_IDLE;
      default:           state_nxt = ksac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    unique case (state_r)
      ksac_pkg::ST_IDLE: in_ready = 1'b1;
      ksac_pkg::ST_BUSY: in_ready = 1'b0;
      default:           in_ready = 1'b0;
    endcase
  end

  always_comb begin
    wr.en   = finish;
    wr.addr = idx_r;
    wr.data = cnt_sum;
  end

  ksac_cnt_ram u_cnt_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (pick_idx),
    .rd_data (rd_data),
    .wr      (wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ksac_pkg::ST_IDLE;
      used_r      <= '0;
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        cnt_vld_r[idx_r] <= 1'b1;
        out_valid_r      <= 1'b1;
        for (int i = 0; i < ksac_pkg::SLOTS; i++) begin
          if (fresh_r && idx_r == ksac_pkg::idx_t'(i)) begin
            used_r[i] <= 1'b1;
          end
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r    <= pick_idx;
      fresh_r  <= pick_fresh;
      id_r     <= in_work_id;
      pri_r    <= in_priority_req;
      rd_vld_r <= cnt_vld_r[pick_idx];
    end
    if (finish) begin
      out_idx_r   <= idx_r;
      out_fresh_r <= fresh_r;
      out_cnt_r   <= cnt_sum;
      for (int i = 0; i < ksac_pkg::SLOTS; i++) begin
        if (fresh_r && idx_r == ksac_pkg::idx_t'(i)) begin
          key_id_r[i]  <= id_r;
          key_pri_r[i] <= pri_r;
        end
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_slot_index      = ksac_pkg::SLOT_INDEX_W'(out_idx_r);
  assign out_newly_allocated = out_fresh_r;
  assign out_enqueue_count   = out_cnt_r;

endmodule

FILE: rtl/ksac_cnt_ram.sv
`timescale 1ns / 1ps

module ksac_cnt_ram (
  input  logic              clk,
  input  logic              rd_en,
  input  ksac_pkg::idx_t    rd_addr,
  output ksac_pkg::cnt_t    rd_data,
  input  ksac_pkg::ram_wr_t wr
);

  ksac_pkg::cnt_t mem [ksac_pkg::CNT_DEPTH];
  ksac_pkg::cnt_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/ksac_checker.sv
`timescale 1ns / 1ps
`include "keyed_slot_allocate_and_count_unit_assert.svh"

module ksac_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [ksac_pkg::ID_W-1:0]           in_work_id,
  input logic [ksac_pkg::PRI_W-1:0]          in_priority_req,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [ksac_pkg::SLOT_INDEX_W-1:0]   out_slot_index,
  input logic                                out_newly_allocated,
  input logic [ksac_pkg::CNT_W-1:0]          out_enqueue_count
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // one word in flight: no accept in the cycle after an accept
  `KSAC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_acc, !in_ready)

  // a waiting input word stays put until taken
  `KSAC_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready,
    in_valid && $stable(in_work_id) && $stable(in_priority_req))

  // a claimed slot is a real slot, never the overflow one
  `KSAC_ASSERT_NOW(a_fresh_in_range, clk, rst_n, out_valid && out_newly_allocated,
    out_slot_index < ksac_pkg::SLOT_INDEX_W'(ksac_pkg::SLOTS))

  // a newly claimed slot has seen exactly one enqueue
  `KSAC_ASSERT_NOW(a_fresh_count_one, clk, rst_n, out_acc && out_newly_allocated,
    out_enqueue_count == ksac_pkg::CNT_W'(1))

  `KSAC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_slot_index) && $stable(out_enqueue_count))

endmodule

bind keyed_slot_allocate_and_count_unit ksac_checker u_ksac_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .in_work_id          (in_work_id),
  .in_priority_req     (in_priority_req),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_slot_index      (out_slot_index),
  .out_newly_allocated (out_newly_allocated),
  .out_enqueue_count   (out_enqueue_count)
);
